// ===== sv/gidr_pkg.sv =====
`default_nettype none

package gidr_pkg;

    // Fixed field widths
    localparam int unsigned FIELD_W = 32;
    localparam int unsigned CFG_W   = 9;

    // Operation codes
    localparam logic [1:0] OP_QUERY     = 2'd0;
    localparam logic [1:0] OP_WR_RANGE  = 2'd1;
    localparam logic [1:0] OP_WR_OFFSET = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_RANGE = 2'd1;
    localparam logic [1:0] ST_PART_OVF = 2'd2;

    // Configuration register indexes
    localparam logic CFG_PARTS = 1'b0;
    localparam logic CFG_TYPES = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  entry_index;
        logic [31:0] range_start_value;
        logic [31:0] range_end_value;
        logic [31:0] offset_value;
        logic [31:0] query_id;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  type_index;
        logic [31:0] local_id;
        logic [1:0]  status;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic init;
        logic probe;
        logic step;
        logic div_load;
        logic div_step;
        logic look;
        logic offs;
        logic fin;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic len_zero;
        logic no_range;
        logic div_done;
        logic out_blocked;
    } t_sts;

endpackage

`default_nettype wire

// ===== sv/gidr_ctrl.sv =====
`default_nettype none

module gidr_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [1:0]      i_operation,
    input  wire gidr_pkg::t_sts  i_sts,
    output gidr_pkg::t_cmd       o_cmd,
    output logic                 o_stall
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_INIT  = 8'b0000_0010,
        S_PROBE = 8'b0000_0100,
        S_CMP   = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_LOOK  = 8'b0010_0000,
        S_OFFS  = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Take items only while idle
    assign o_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = i_valid;
                if (i_valid && (i_operation == gidr_pkg::OP_QUERY)) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_PROBE;
            end
            S_PROBE: begin
                if (i_sts.len_zero) begin
                    if (i_sts.no_range) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.div_load = 1'b1;
                        n_state        = S_DIV;
                    end
                end else begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = S_PROBE;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_LOOK;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_OFFS;
            end
            S_OFFS: begin
                o_cmd.offs = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_blocked) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== sv/gidr_dp.sv =====
`default_nettype none

module gidr_dp #(
    parameter int unsigned MAX_RANGES = 256,
    parameter int unsigned ID_BITS    = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire gidr_pkg::t_cmd               i_cmd,
    output gidr_pkg::t_sts                    o_sts,
    input  wire gidr_pkg::t_in_item           i_in,
    input  wire logic                         i_stall,
    output logic                              o_valid,
    output gidr_pkg::t_out_item               o_out,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_idx,
    input  wire logic [gidr_pkg::CFG_W-1:0]   i_cfg_wdata
);

    localparam int unsigned IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);
    localparam int unsigned DC_W  = $clog2(CNT_W + 1);
    localparam int unsigned OI_W  = ((CNT_W > 18) ? CNT_W : 18) + 1;
    localparam int unsigned FW    = gidr_pkg::FIELD_W;
    localparam int unsigned CW    = gidr_pkg::CFG_W;

    // Tables
    logic [ID_BITS-1:0] r_start_mem [MAX_RANGES];
    logic [ID_BITS-1:0] r_end_mem   [MAX_RANGES];
    logic [ID_BITS-1:0] r_off_mem   [MAX_RANGES];

    logic [CW-1:0]      r_parts;
    logic [CW-1:0]      r_types;

    logic [ID_BITS-1:0] r_id;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_first;
    logic [CNT_W-1:0]   r_len;
    logic [ID_BITS-1:0] r_end_q;
    logic [ID_BITS-1:0] r_start_q;
    logic [ID_BITS-1:0] r_off_q;
    logic [CNT_W-1:0]   r_quo;
    logic [CW-1:0]      r_rem;
    logic [DC_W-1:0]    r_div_cnt;
    logic [17:0]        r_prod;
    logic [ID_BITS-1:0] r_base;
    logic               r_oi_ok;
    logic               r_out_valid;
    gidr_pkg::t_out_item r_out;

    logic [CNT_W-1:0]   n_first;
    logic [CNT_W-1:0]   n_len;
    logic [CW:0]        n_rem_sh;
    logic               w_ge;

    logic [IDX_W-1:0]   w_wr_addr;
    logic               w_wr_ok;
    logic [17:0]        w_cnt_full;
    logic [CNT_W-1:0]   w_half;
    logic [CNT_W-1:0]   w_probe;
    logic [OI_W-1:0]    w_oi;
    logic               w_no_range;
    logic               w_part_ovf;
    logic [ID_BITS-1:0] w_local;

    // Write address and range check
    assign w_wr_addr = IDX_W'(i_in.entry_index);
    assign w_wr_ok   = ({24'd0, i_in.entry_index} < 32'(MAX_RANGES));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parts <= CW'(1);
            r_types <= CW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gidr_pkg::CFG_PARTS: r_parts <= i_cfg_wdata;
                gidr_pkg::CFG_TYPES: r_types <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Range tables: write on item, read end at probe, start at lookup
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_in.operation == gidr_pkg::OP_WR_RANGE) && w_wr_ok) begin
            r_start_mem[w_wr_addr] <= ID_BITS'(i_in.range_start_value);
            r_end_mem[w_wr_addr]   <= ID_BITS'(i_in.range_end_value);
        end
        if (i_cmd.probe) begin
            r_end_q <= r_end_mem[w_probe[IDX_W-1:0]];
        end
        if (i_cmd.look) begin
            r_start_q <= r_start_mem[r_first[IDX_W-1:0]];
        end
    end

    // Offset table
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_in.operation == gidr_pkg::OP_WR_OFFSET) && w_wr_ok) begin
            r_off_mem[w_wr_addr] <= ID_BITS'(i_in.offset_value);
        end
        if (i_cmd.offs) begin
            r_off_q <= r_off_mem[w_oi[IDX_W-1:0]];
        end
    end

    // Search step
    assign w_cnt_full = 18'(r_parts) * 18'(r_types);
    assign w_half     = r_len >> 1;
    assign w_probe    = r_first + w_half;

    always_comb begin
        n_first = r_first;
        n_len   = w_half;
        if (r_end_q < r_id) begin
            n_first = w_probe + CNT_W'(1);
            n_len   = r_len - w_half - CNT_W'(1);
        end
    end

    // Restoring divide step: range by type count
    assign n_rem_sh = {r_rem, r_quo[CNT_W-1]};
    assign w_ge     = (n_rem_sh >= {1'b0, r_types});

    // Offset index: parts * type + part - 1
    assign w_oi = OI_W'(r_prod) + OI_W'(r_quo) - OI_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_id <= ID_BITS'(i_in.query_id);
        end
        if (i_cmd.init) begin
            r_count <= (w_cnt_full > 18'(MAX_RANGES)) ? CNT_W'(MAX_RANGES)
                                                      : CNT_W'(w_cnt_full);
            r_first <= '0;
            r_len   <= (w_cnt_full > 18'(MAX_RANGES)) ? CNT_W'(MAX_RANGES)
                                                      : CNT_W'(w_cnt_full);
        end else if (i_cmd.step) begin
            r_first <= n_first;
            r_len   <= n_len;
        end
        if (i_cmd.div_load) begin
            r_quo <= r_first;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[CNT_W-2:0], w_ge};
            r_rem <= w_ge ? CW'(n_rem_sh - {1'b0, r_types}) : CW'(n_rem_sh);
        end
        if (i_cmd.look) begin
            r_prod <= 18'(r_parts) * 18'(r_rem);
        end
        if (i_cmd.offs) begin
            r_base  <= r_id - r_start_q;
            r_oi_ok <= (r_quo != '0) && (w_oi < OI_W'(MAX_RANGES));
        end
    end

    // Divide step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_load) begin
            r_div_cnt <= DC_W'(CNT_W);
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt - DC_W'(1);
        end
    end

    // Result
    assign w_no_range = (r_first == r_count);
    assign w_part_ovf = (OI_W'(r_quo) >= OI_W'(r_parts));
    assign w_local    = r_base + (r_oi_ok ? r_off_q : '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            if (w_no_range) begin
                r_out.type_index <= '0;
                r_out.local_id   <= '0;
                r_out.status     <= gidr_pkg::ST_NO_RANGE;
            end else if (w_part_ovf) begin
                r_out.type_index <= r_rem[7:0];
                r_out.local_id   <= '0;
                r_out.status     <= gidr_pkg::ST_PART_OVF;
            end else begin
                r_out.type_index <= r_rem[7:0];
                r_out.local_id   <= FW'(w_local);
                r_out.status     <= gidr_pkg::ST_OK;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    assign o_sts.len_zero    = (r_len == '0);
    assign o_sts.no_range    = w_no_range;
    assign o_sts.div_done    = (r_div_cnt == '0);
    assign o_sts.out_blocked = r_out_valid && i_stall;

endmodule

`default_nettype wire

// ===== sv/global_id_range_to_type_local_id.sv =====
// Global id to type / local id mapper. Load the range tables (operation 1:
// first and inclusive last id per entry, last ids ascending) and the offset
// table (operation 2), set partition_count and type_count, then send queries
// (operation 0). Each query returns one item with the type, the local id and
// a status (ok, no range, partition overflow); writes return nothing and leave
// the input free for the next item. A query is worked by a controller and a
// datapath: a lower-bound binary search over the end table, a probe state and
// a compare state per probe on its single read port, then a restoring divider
// by type_count, one quotient bit per cycle, then start and offset lookups.
// The input stays stalled while a query is worked, and longer while an earlier
// result still waits at the output, so no new item is taken before the query
// is finished. A query with no matching range skips the divider and lookups.
// The next item is taken while a finished result still waits in the output
// register.
`default_nettype none

module global_id_range_to_type_local_id #(
    parameter int unsigned MAX_RANGES = 256,
    parameter int unsigned ID_BITS    = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire gidr_pkg::t_in_item           i_in,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output gidr_pkg::t_out_item               o_out,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_idx,
    input  wire logic [gidr_pkg::CFG_W-1:0]   i_cfg_wdata
);

    gidr_pkg::t_cmd w_cmd;
    gidr_pkg::t_sts w_sts;

    gidr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_in.operation),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_stall     (o_stall)
    );

    gidr_dp #(
        .MAX_RANGES (MAX_RANGES),
        .ID_BITS    (ID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in        (i_in),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

endmodule

`default_nettype wire

// ===== sv/gidr_chk.sv =====
`default_nettype none

module gidr_chk (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_valid,
    input wire logic                 o_stall,
    input wire gidr_pkg::t_in_item   i_in,
    input wire logic                 o_valid,
    input wire logic                 i_stall,
    input wire gidr_pkg::t_out_item  o_out
);

    // A query item holds the input side busy on the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_in.operation == gidr_pkg::OP_QUERY)) |=> o_stall)
        else $error("input not stalled after query item");

    // A write item leaves the input side free on the next cycle
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_in.operation != gidr_pkg::OP_QUERY)) |=> !o_stall)
        else $error("input stalled after write item");

    // No-range results carry zero type and local id
    a_no_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.status == gidr_pkg::ST_NO_RANGE))
            |-> ((o_out.type_index == 8'd0) && (o_out.local_id == 32'd0)))
        else $error("no-range result with nonzero fields");

    // Status is one of the three defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_out.status == gidr_pkg::ST_OK) ||
                     (o_out.status == gidr_pkg::ST_NO_RANGE) ||
                     (o_out.status == gidr_pkg::ST_PART_OVF)))
        else $error("undefined status code");

    // A stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out)))
        else $error("stalled result item changed");

endmodule

bind global_id_range_to_type_local_id gidr_chk u_chk (.*);

`default_nettype wire
